// ===== design/mrrc_pkg.sv =====
// Shared types and constants for the Modbus RTU read response checker.
// Holds the word structs, the status codes and the configuration register map.
// No dependencies.
package mrrc_pkg;

    localparam int MAX_REGISTERS_DEF = 16;
    localparam int COUNT_W           = 6;
    localparam int REG_COUNT_W       = 5;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  EXC_MASK   = 8'h80;
    localparam logic [7:0]  SLAVE_RST  = 8'h01;
    localparam logic [REG_COUNT_W-1:0] REG_COUNT_RST = REG_COUNT_W'(5);

    localparam logic REG_SLAVE_ADDRESS  = 1'b0;
    localparam logic REG_REGISTER_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_RESPONSE = 3'd1,
        ST_BAD_ADDRESS = 3'd2,
        ST_TOO_SHORT   = 3'd3,
        ST_CRC_ERROR   = 3'd4,
        ST_EXCEPTION   = 3'd5
    } status_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic [7:0] exception_code;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [7:0]             slave_address;
        logic [REG_COUNT_W-1:0] register_count;
    } cfg_t;

    typedef struct packed {
        logic                   valid;
        status_t                status;
        logic [7:0]             exception_code;
        logic [REG_COUNT_W-1:0] n_regs;
    } done_t;

endpackage

// ===== design/mrrc_cfg.sv =====
// Configuration registers behind the APB-style port.
// Depends on mrrc_pkg.
module mrrc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrrc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mrrc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mrrc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output mrrc_pkg::cfg_t                 cfg
);
    import mrrc_pkg::*;

    logic [7:0]             slave_address_reg;
    logic [REG_COUNT_W-1:0] register_count_reg;
    logic                   wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg  <= SLAVE_RST;
            register_count_reg <= REG_COUNT_RST;
        end
        else if (wr_fire)
        begin
            case (paddr[2])
                REG_SLAVE_ADDRESS:  slave_address_reg  <= pwdata[7:0];
                REG_REGISTER_COUNT: register_count_reg <= pwdata[REG_COUNT_W-1:0];
                default:            slave_address_reg  <= slave_address_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SLAVE_ADDRESS:  prdata = CFG_DATA_W'(slave_address_reg);
            REG_REGISTER_COUNT: prdata = CFG_DATA_W'(register_count_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.slave_address  = slave_address_reg;
    assign cfg.register_count = register_count_reg;

endmodule

// ===== design/mrrc_frame.sv =====
// Frame tracker: byte count, CRC-16 accumulation, header and CRC capture,
// payload write port and the end-of-frame verdict. Depends on mrrc_pkg.
module mrrc_frame #(
    parameter int MAX_REGISTERS = mrrc_pkg::MAX_REGISTERS_DEF,
    parameter int AW            = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  mrrc_pkg::in_word_t word,
    input  mrrc_pkg::cfg_t     cfg,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [7:0]         wr_data,
    output mrrc_pkg::done_t    done
);
    import mrrc_pkg::*;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    logic [COUNT_W-1:0]     byte_count_reg,   byte_count_next;
    logic [15:0]            crc_accum_reg,    crc_accum_next;
    logic [15:0]            received_crc_reg, received_crc_next;
    logic [7:0]             first_byte_reg,   first_byte_next;
    logic [7:0]             function_byte_reg, function_byte_next;
    logic [7:0]             third_byte_reg,   third_byte_next;

    logic [REG_COUNT_W-1:0] n_eff;
    logic [COUNT_W-1:0]     body;
    logic                   is_byte;
    logic                   is_eof;
    status_t                verdict;

    always_comb
    begin
        if (cfg.register_count == '0)
            n_eff = REG_COUNT_W'(1);
        else if (cfg.register_count > REG_COUNT_W'(MAX_REGISTERS))
            n_eff = REG_COUNT_W'(MAX_REGISTERS);
        else
            n_eff = cfg.register_count;
    end

    assign body    = COUNT_W'(3) + COUNT_W'({n_eff, 1'b0});
    assign is_byte = accept && !word.func;
    assign is_eof  = accept && word.func;

    always_comb
    begin
        if (byte_count_reg == '0)
            verdict = ST_NO_RESPONSE;
        else if (first_byte_reg != cfg.slave_address)
            verdict = ST_BAD_ADDRESS;
        else if (byte_count_reg < body + COUNT_W'(2))
            verdict = ST_TOO_SHORT;
        else if (crc_accum_reg != received_crc_reg)
            verdict = ST_CRC_ERROR;
        else if ((function_byte_reg & EXC_MASK) != 8'h00)
            verdict = ST_EXCEPTION;
        else
            verdict = ST_OK;
    end

    always_comb
    begin
        byte_count_next    = byte_count_reg;
        crc_accum_next     = crc_accum_reg;
        received_crc_next  = received_crc_reg;
        first_byte_next    = first_byte_reg;
        function_byte_next = function_byte_reg;
        third_byte_next    = third_byte_reg;
        wr_en              = 1'b0;
        if (is_byte)
        begin
            if (byte_count_reg < body)
            begin
                crc_accum_next = crc16_byte(crc_accum_reg, word.rx_byte);
                case (byte_count_reg)
                    COUNT_W'(0): first_byte_next    = word.rx_byte;
                    COUNT_W'(1): function_byte_next = word.rx_byte;
                    COUNT_W'(2): third_byte_next    = word.rx_byte;
                    default:     wr_en              = 1'b1;
                endcase
            end
            else if (byte_count_reg == body)
                received_crc_next[7:0] = word.rx_byte;
            else if (byte_count_reg == body + COUNT_W'(1))
                received_crc_next[15:8] = word.rx_byte;
            if (byte_count_reg != '1)
                byte_count_next = byte_count_reg + COUNT_W'(1);
        end
        else if (is_eof)
        begin
            byte_count_next    = '0;
            crc_accum_next     = CRC_INIT;
            received_crc_next  = '0;
            first_byte_next    = '0;
            function_byte_next = '0;
            third_byte_next    = '0;
        end
    end

    assign wr_addr = AW'(byte_count_reg - COUNT_W'(3));
    assign wr_data = word.rx_byte;

    assign done.valid          = is_eof;
    assign done.status         = verdict;
    assign done.exception_code = (verdict == ST_EXCEPTION) ? third_byte_reg : 8'h00;
    assign done.n_regs         = n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            crc_accum_reg     <= CRC_INIT;
            received_crc_reg  <= '0;
            first_byte_reg    <= '0;
            function_byte_reg <= '0;
            third_byte_reg    <= '0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            crc_accum_reg     <= crc_accum_next;
            received_crc_reg  <= received_crc_next;
            first_byte_reg    <= first_byte_next;
            function_byte_reg <= function_byte_next;
            third_byte_reg    <= third_byte_next;
        end
    end

endmodule

// ===== design/mrrc_out.sv =====
// Payload memory, drain sequencer and output register.
// Depends on mrrc_pkg.
module mrrc_out #(
    parameter int MAX_REGISTERS = mrrc_pkg::MAX_REGISTERS_DEF,
    parameter int AW            = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [7:0]          wr_data,
    input  mrrc_pkg::done_t     done,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_stall,
    output mrrc_pkg::out_word_t out_word
);
    import mrrc_pkg::*;

    localparam int DEPTH = 2 * MAX_REGISTERS;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;

    logic          out_valid_reg,  out_valid_next;
    logic [2:0]    status_reg,     status_next;
    logic [7:0]    exc_reg,        exc_next;
    logic          last_reg,       last_next;
    logic          is_data_reg,    is_data_next;
    logic          drain_reg,      drain_next;
    logic [AW-1:0] idx_reg,        idx_next;
    logic [AW-1:0] last_idx_reg,   last_idx_next;

    logic          out_load;
    logic          drain_fire;

    assign out_load   = !out_valid_reg || !out_stall;
    assign drain_fire = drain_reg && out_load;
    assign busy       = drain_reg || (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (drain_fire)
            rd_data_reg <= mem[idx_reg];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        exc_next       = exc_reg;
        last_next      = last_reg;
        is_data_next   = is_data_reg;
        drain_next     = drain_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        if (out_load)
            out_valid_next = 1'b0;
        if (drain_fire)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            exc_next       = 8'h00;
            last_next      = (idx_reg == last_idx_reg);
            is_data_next   = 1'b1;
            idx_next       = idx_reg + AW'(1);
            if (idx_reg == last_idx_reg)
                drain_next = 1'b0;
        end
        else if (done.valid)
        begin
            if (done.status == ST_OK)
            begin
                drain_next    = 1'b1;
                idx_next      = '0;
                last_idx_next = AW'(COUNT_W'({done.n_regs, 1'b0}) - COUNT_W'(1));
            end
            else
            begin
                out_valid_next = 1'b1;
                status_next    = done.status;
                exc_next       = done.exception_code;
                last_next      = 1'b1;
                is_data_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            drain_reg     <= 1'b0;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            status_reg    <= '0;
            exc_reg       <= '0;
            last_reg      <= 1'b0;
            is_data_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            drain_reg     <= drain_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            status_reg    <= status_next;
            exc_reg       <= exc_next;
            last_reg      <= last_next;
            is_data_reg   <= is_data_next;
        end
    end

    assign out_valid               = out_valid_reg;
    assign out_word.status         = status_reg;
    assign out_word.data_byte      = is_data_reg ? rd_data_reg : 8'h00;
    assign out_word.exception_code = exc_reg;
    assign out_word.last           = last_reg;

endmodule

// ===== design/modbus_rtu_read_response_checker_unit.sv =====
// Modbus RTU function 03 response checker, top level.
// Depends on mrrc_pkg, mrrc_cfg, mrrc_frame and mrrc_out.
//
// Received bytes are taken one per clock cycle while in_stall is low: each
// byte updates the CRC-16 and the frame capture registers in the cycle it
// is accepted and produces no output word. An end-of-frame word ending in
// an error yields one status word and leaves the input free unless the
// receiver stalls that word. An end-of-frame word with a good frame streams
// the 2N payload bytes out of the payload memory through its single read
// port, one word per cycle while out_stall is low; in_stall stays high until
// the last byte is read out and whenever the output holds a stalled word.
module modbus_rtu_read_response_checker_unit #(
    parameter int MAX_REGISTERS = mrrc_pkg::MAX_REGISTERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  mrrc_pkg::in_word_t             in_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output mrrc_pkg::out_word_t            out_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrrc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mrrc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mrrc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import mrrc_pkg::*;

    localparam int AW = $clog2(2 * MAX_REGISTERS);

    cfg_t          cfg;
    done_t         done;
    logic          accept;
    logic          busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    mrrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrrc_frame #(
        .MAX_REGISTERS (MAX_REGISTERS),
        .AW            (AW)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .word    (in_word),
        .cfg     (cfg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .done    (done)
    );

    mrrc_out #(
        .MAX_REGISTERS (MAX_REGISTERS),
        .AW            (AW)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .done      (done),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

// ===== test/response_frame_monitor.sv =====
// Watches the word channels and the register port of the Modbus RTU read response checker.
// Predicts the result words of every accepted input word and compares them in order.
// Depends on mrrc_pkg.
module response_frame_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  mrrc_pkg::in_word_t              in_word,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  mrrc_pkg::out_word_t             out_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mrrc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mrrc_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              mismatches,
    output int                              outstanding,
    output int                              results_seen
);
    import mrrc_pkg::*;

    localparam int PAYLOAD_DEPTH = 2 * MAX_REGISTERS_DEF;
    localparam logic [COUNT_W-1:0] LEN_SATURATED = '1;

    logic [7:0]             addr_cfg;
    logic [REG_COUNT_W-1:0] count_cfg;
    logic [COUNT_W-1:0]     frame_len;
    logic [15:0]            crc_run;
    logic [15:0]            crc_rx;
    logic [7:0]             addr_byte;
    logic [7:0]             fn_byte;
    logic [7:0]             exc_byte;
    logic [7:0]             payload [PAYLOAD_DEPTH];
    out_word_t              awaited_words [$];
    int                     err_count;
    int                     result_count;

    function automatic int regs_in_use(input logic [REG_COUNT_W-1:0] raw);
        int n;
        n = int'(raw);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > MAX_REGISTERS_DEF)
        begin
            n = MAX_REGISTERS_DEF;
        end
        return n;
    endfunction

    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic clear_frame();
        frame_len = '0;
        crc_run   = CRC_INIT;
        crc_rx    = '0;
        addr_byte = '0;
        fn_byte   = '0;
        exc_byte  = '0;
    endtask

    task automatic check_field(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        status_t   verdict;
        int        n;
        int        body;
        if (!rst_n)
        begin
            addr_cfg  = SLAVE_RST;
            count_cfg = REG_COUNT_RST;
            clear_frame();
            foreach (payload[k])
            begin
                payload[k] = '0;
            end
            awaited_words.delete();
            err_count    = 0;
            result_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (awaited_words.size() == 0)
                begin
                    $display("%0t: unexpected result word: expected none, actual %p",
                             $time, out_word);
                    err_count++;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    check_field("status", 8'(want.status), 8'(out_word.status));
                    check_field("data_byte", want.data_byte, out_word.data_byte);
                    check_field("exception_code", want.exception_code,
                                out_word.exception_code);
                    check_field("last", 8'(want.last), 8'(out_word.last));
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                if (paddr[CFG_ADDR_W-1:2] == REG_REGISTER_COUNT)
                begin
                    count_cfg = pwdata[REG_COUNT_W-1:0];
                end
                else
                begin
                    addr_cfg = pwdata[7:0];
                end
            end

            if (in_valid && !in_stall)
            begin
                n    = regs_in_use(count_cfg);
                body = 3 + 2 * n;
                if (!in_word.func)
                begin
                    if (int'(frame_len) < body)
                    begin
                        crc_run = crc_next(crc_run, in_word.rx_byte);
                        case (int'(frame_len))
                            0: addr_byte = in_word.rx_byte;
                            1: fn_byte   = in_word.rx_byte;
                            2: exc_byte  = in_word.rx_byte;
                            default: payload[int'(frame_len) - 3] = in_word.rx_byte;
                        endcase
                    end
                    else if (int'(frame_len) == body)
                    begin
                        crc_rx[7:0] = in_word.rx_byte;
                    end
                    else if (int'(frame_len) == body + 1)
                    begin
                        crc_rx[15:8] = in_word.rx_byte;
                    end
                    if (frame_len != LEN_SATURATED)
                    begin
                        frame_len++;
                    end
                end
                else
                begin
                    if (frame_len == 0)
                        verdict = ST_NO_RESPONSE;
                    else if (addr_byte != addr_cfg)
                        verdict = ST_BAD_ADDRESS;
                    else if (int'(frame_len) < body + 2)
                        verdict = ST_TOO_SHORT;
                    else if (crc_run != crc_rx)
                        verdict = ST_CRC_ERROR;
                    else if ((fn_byte & EXC_MASK) != 0)
                        verdict = ST_EXCEPTION;
                    else
                        verdict = ST_OK;

                    if (verdict == ST_OK)
                    begin
                        for (int k = 0; k < 2 * n; k++)
                        begin
                            want.status         = ST_OK;
                            want.data_byte      = payload[k];
                            want.exception_code = '0;
                            want.last           = (k == 2 * n - 1);
                            awaited_words.push_back(want);
                        end
                    end
                    else
                    begin
                        want.status         = verdict;
                        want.data_byte      = '0;
                        want.exception_code = (verdict == ST_EXCEPTION) ? exc_byte : 8'h00;
                        want.last           = 1'b1;
                        awaited_words.push_back(want);
                    end
                    clear_frame();
                end
            end
        end
        mismatches   <= err_count;
        outstanding  <= awaited_words.size();
        results_seen <= result_count;
    end

endmodule

// ===== test/modbus_rtu_read_response_checker_unit_test.sv =====
// Stimulus and verdict for the Modbus RTU read response checker.
// Builds response frames of every outcome, drives the register port and both channels.
// Depends on mrrc_pkg, the block under test and response_frame_monitor.
module modbus_rtu_read_response_checker_unit_test;
    import mrrc_pkg::*;

    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 2 * MAX_REGISTERS_DEF + 8;
    localparam int STUCK_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef enum int {
        FR_GOOD,
        FR_EXCEPTION,
        FR_BAD_CRC,
        FR_SHORT,
        FR_BAD_ADDR,
        FR_LONG,
        FR_NOISE,
        FR_SILENT
    } frame_kind_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int outstanding;
    int results_seen;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_len      = 0;
    int words_sent    = 0;
    int frames_sent   = 0;
    int settings_used = 0;

    logic [7:0]             cur_slave;
    logic [REG_COUNT_W-1:0] cur_count;
    logic [7:0]             frame_bytes [$];

    modbus_rtu_read_response_checker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    response_frame_monitor monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_word      (in_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_word     (out_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        int held;
        held      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (held < hold_len)
            begin
                out_stall <= 1'b1;
                held++;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable && pready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int regs_for(input logic [REG_COUNT_W-1:0] raw);
        int n;
        n = int'(raw);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > MAX_REGISTERS_DEF)
        begin
            n = MAX_REGISTERS_DEF;
        end
        return n;
    endfunction

    function automatic logic [15:0] frame_crc();
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (frame_bytes[k])
        begin
            crc ^= {8'h00, frame_bytes[k]};
            repeat (8)
            begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    task automatic push_word(input logic func, input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_word.func    <= func;
        in_word.rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_bytes(input int from, input int upto);
        for (int k = from; k < upto; k++)
        begin
            push_word(1'b0, frame_bytes[k]);
        end
    endtask

    task automatic send_eof();
        push_word(1'b1, 8'($urandom));
        frames_sent++;
    endtask

    task automatic send_frame();
        send_bytes(0, frame_bytes.size());
        send_eof();
    endtask

    task automatic start_frame(input int n, input logic [7:0] fn, input logic [7:0] third);
        frame_bytes.delete();
        frame_bytes.push_back(cur_slave);
        frame_bytes.push_back(fn);
        frame_bytes.push_back(third);
        for (int k = 0; k < 2 * n; k++)
        begin
            frame_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic seal_frame();
        logic [15:0] crc;
        crc = frame_crc();
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    task automatic build_frame(input frame_kind_t kind, input bit to_limit);
        int n;
        int keep;
        int extra;
        n = regs_for(cur_count);
        if (kind == FR_SILENT)
        begin
            frame_bytes.delete();
        end
        else if (kind == FR_NOISE)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 12))
            begin
                frame_bytes.push_back(8'($urandom));
            end
            if ($urandom_range(3) == 0)
            begin
                frame_bytes[0] = cur_slave;
            end
        end
        else
        begin
            if (kind == FR_EXCEPTION)
                start_frame(n, EXC_MASK | 8'($urandom), 8'($urandom));
            else
                start_frame(n, $urandom_range(1) ? 8'h03 : (8'($urandom) & ~EXC_MASK),
                            $urandom_range(1) ? 8'(2 * n) : 8'($urandom));
            seal_frame();
            case (kind)
                FR_BAD_CRC:
                begin
                    keep = frame_bytes.size() - 1 - $urandom_range(1);
                    frame_bytes[keep] ^= 8'(1 << $urandom_range(7));
                end
                FR_BAD_ADDR:
                begin
                    frame_bytes[0] ^= 8'($urandom_range(1, 255));
                    keep = $urandom_range(1, frame_bytes.size());
                    frame_bytes = frame_bytes[0:keep-1];
                end
                FR_SHORT:
                begin
                    keep = $urandom_range(1, frame_bytes.size() - 1);
                    frame_bytes = frame_bytes[0:keep-1];
                end
                FR_LONG:
                begin
                    extra = to_limit ? 64 - frame_bytes.size() : $urandom_range(1, 8);
                    repeat (extra)
                    begin
                        frame_bytes.push_back(8'($urandom));
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic random_frames(input int budget);
        int          start;
        int          pick;
        frame_kind_t kind;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                kind = FR_GOOD;
            else if (pick < 60)
                kind = FR_EXCEPTION;
            else if (pick < 68)
                kind = FR_BAD_CRC;
            else if (pick < 76)
                kind = FR_SHORT;
            else if (pick < 82)
                kind = FR_BAD_ADDR;
            else if (pick < 88)
                kind = FR_LONG;
            else if (pick < 95)
                kind = FR_NOISE;
            else
                kind = FR_SILENT;
            build_frame(kind, 1'b0);
            send_frame();
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] slave, input logic [REG_COUNT_W-1:0] count);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_SLAVE_ADDRESS, CFG_DATA_W'(slave));
        write_reg(REG_REGISTER_COUNT, CFG_DATA_W'(count));
        cur_slave = slave;
        cur_count = count;
        settings_used++;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        cur_slave = SLAVE_RST;
        cur_count = REG_COUNT_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        configure(8'h00, 5'd0);
        build_frame(FR_SILENT, 1'b0);
        send_frame();
        frame_bytes = {8'hFF};
        send_frame();
        start_frame(1, 8'h03, 8'h02);
        seal_frame();
        void'(frame_bytes.pop_back());
        send_frame();
        start_frame(1, 8'h03, 8'h02);
        frame_bytes[3] = 8'h00;
        frame_bytes[4] = 8'hFF;
        seal_frame();
        send_frame();
        start_frame(1, 8'hFF, 8'hFF);
        seal_frame();
        send_frame();

        // grow the count after the header, then shrink it past the payload
        start_frame(MAX_REGISTERS_DEF, 8'h03, 8'(2 * MAX_REGISTERS_DEF));
        seal_frame();
        send_bytes(0, 3);
        configure(cur_slave, 5'd16);
        send_bytes(3, frame_bytes.size());
        send_eof();
        start_frame(MAX_REGISTERS_DEF, 8'h03, 8'(2 * MAX_REGISTERS_DEF));
        seal_frame();
        send_bytes(0, 11);
        configure(cur_slave, 5'd1);
        send_bytes(11, frame_bytes.size());
        send_eof();
        build_frame(FR_LONG, 1'b1);
        send_frame();

        configure(8'hFF, 5'd31);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        random_frames(45);

        configure(8'h01, 5'd1);
        in_idle_pct   = 59;
        out_stall_pct = 0;
        random_frames(55);

        configure(8'($urandom), 5'd3);
        in_idle_pct   = 0;
        out_stall_pct = 59;
        hold_len     <= HOLD_OFF_CYCLES;
        random_frames(65);

        configure(8'($urandom), 5'd2);
        in_idle_pct   = 17;
        out_stall_pct = 17;
        random_frames(55);

        configure(SLAVE_RST, REG_COUNT_RST);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        random_frames(35);

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input words in %0d frames over %0d register settings.",
                 words_sent, frames_sent, settings_used);
        $display("Compared %0d result words, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/mrrc_pkg.sv
design/mrrc_cfg.sv
design/mrrc_frame.sv
design/mrrc_out.sv
design/modbus_rtu_read_response_checker_unit.sv
test/response_frame_monitor.sv
test/modbus_rtu_read_response_checker_unit_test.sv
